// ===== rtl/core/hsfc_pkg.sv =====
// Package for the half/single float converter: codes, constants and the
// narrowing and widening functions. No dependencies.
`timescale 1ns / 1ps
package hsfc_pkg;

    typedef enum logic {
        FUNC_NARROW = 1'b0,
        FUNC_WIDEN  = 1'b1
    } func_t;

    localparam logic [15:0] HALF_INF    = 16'h7C00;
    localparam logic [15:0] HALF_QUIET  = 16'h0200;
    localparam logic [31:0] SINGLE_INF  = 32'h7F80_0000;
    localparam int          SINGLE_BIAS = 127;
    localparam int          HALF_BIAS   = 15;

    // Count leading zeros of a nonzero 10-bit half fraction (0..9).
    function automatic logic [3:0] lzc10(input logic [9:0] f);
        logic [3:0] n;
        n = 4'd9;
        for (int i = 0; i < 10; i++) begin
            if (f[i])
            begin
                n = 4'(9 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [15:0] narrow(input logic [31:0] x);
        logic        s;
        logic [7:0]  e;
        logic [22:0] f;
        logic [4:0]  sh;      // 1..11 extra bits beyond 13 for subnormals
        logic [23:0] full;
        logic [23:0] kept;
        logic [23:0] halfb;
        logic        rbit;
        logic        sticky;
        logic [10:0] r;
        logic [15:0] res;
        s = x[31];
        e = x[30:23];
        f = x[22:0];
        full = {1'b1, f};
        sh = 5'd0;
        kept = '0;
        halfb = '0;
        rbit = 1'b0;
        sticky = 1'b0;
        r = '0;
        if (e == 8'hFF)
        begin
            if (f == '0)
            begin
                res = HALF_INF;
            end
            else
            begin
                res = HALF_INF | HALF_QUIET | {6'd0, f[22:13]};
            end
        end
        else if (e == 8'd0 || e < 8'd102)
        begin
            res = 16'd0;
        end
        else if (e >= 8'd143)
        begin
            res = HALF_INF;
        end
        else if (e <= 8'd112)
        begin
            // shift 14 - e16 = 126 - e, range 14..24
            sh = 5'(8'd126 - e);
            kept = full >> sh;
            halfb = 24'd1 << (sh - 5'd1);
            rbit = (full & halfb) != '0;
            sticky = (full & (halfb - 24'd1)) != '0;
            r = kept[10:0] + 11'((rbit && (sticky || kept[0])) ? 1 : 0);
            res = {5'd0, r};
        end
        else
        begin
            rbit = f[12];
            sticky = f[11:0] != '0;
            r = {1'b0, f[22:13]} + 11'((rbit && (sticky || f[13])) ? 1 : 0);
            // carry from the fraction adds into the exponent field
            res = {1'b0, 5'(e - 8'd112), 10'd0} + {5'd0, r};
        end
        return {s, res[14:0]};
    endfunction

    function automatic logic [31:0] widen(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  f;
        logic [3:0]  n;
        logic [9:0]  fs;
        logic [31:0] res;
        e = h[14:10];
        f = h[9:0];
        n = lzc10(f);
        fs = '0;
        if (e == 5'h1F)
        begin
            res = SINGLE_INF | {9'd0, f, 13'd0};
        end
        else if (e == 5'd0)
        begin
            if (f == '0)
            begin
                res = '0;
            end
            else
            begin
                fs = 10'((f << (n + 4'd1)));
                res = {1'b0, 8'(8'd112 - {4'd0, n}), fs, 13'd0};
            end
        end
        else
        begin
            res = {1'b0, 8'({3'd0, e} + 8'(SINGLE_BIAS - HALF_BIAS)), f, 13'd0};
        end
        return {h[15], res[30:0]};
    endfunction

endpackage

// ===== rtl/core/half_single_float_convert.sv =====
// Top level of the half/single float converter.
// Depends on hsfc_pkg.
`timescale 1ns / 1ps
// One operand per cycle: a beat accepted with start appears on result with
// done high in the next cycle. busy is always low; the result is held in the
// single result register behind the conversion logic.
// The receiver cannot stall: each result beat is on result for exactly one
// cycle and must be taken when done is high.
module half_single_float_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] operand,
    output logic        done,
    output logic [31:0] result
);

    logic        done_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    always_comb
    begin
        unique case (hsfc_pkg::func_t'(func))
            hsfc_pkg::FUNC_NARROW: result_next = {16'd0, hsfc_pkg::narrow(operand)};
            hsfc_pkg::FUNC_WIDEN:  result_next = hsfc_pkg::widen(operand[15:0]);
            default:               result_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/hsfc_checker.sv =====
// Port checker for half_single_float_convert, bound to the top level.
// Depends on no package.
`timescale 1ns / 1ps
module hsfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        func,
    input logic [31:0] operand,
    input logic        done,
    input logic [31:0] result
);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done) else $error("missing result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done) else $error("result beat without input");

    a_narrow_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !func) |=> (result[31:16] == 16'd0))
        else $error("narrow result upper half not zero");

    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && func) |=> (result[31] == $past(operand[15])))
        else $error("widen lost sign");

endmodule

bind half_single_float_convert hsfc_checker u_hsfc_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for half_single_float_convert: drives binary32/binary16 conversions
// and checks every result against an independent predictor. Depends on hsfc_pkg.
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        hsfc_pkg::func_t fn;
        logic [31:0]     bits;
    } conv_req_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [31:0] operand;
    logic        done;
    logic [31:0] result;

    conv_req_t   pending_ops[$];
    logic [31:0] expected_results[$];
    int          mismatches;
    int          cycles;
    int          gap;
    bit          stim_done;

    half_single_float_convert DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .operand(operand), .done(done), .result(result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Round to nearest even, shifting right by sh (1..24).
    function automatic logic [31:0] rne_shift(input logic [31:0] m, input int sh);
        logic [31:0] kept;
        logic [31:0] halfb;
        kept = m >> sh;
        halfb = 32'd1 << (sh - 1);
        if ((m & halfb) != 0 && ((m & (halfb - 1)) != 0 || kept[0]))
        begin
            kept = kept + 1;
        end
        return kept;
    endfunction

    function automatic logic [31:0] to_half(input logic [31:0] x);
        logic [15:0] sgn;
        int          ex;
        logic [31:0] r;
        sgn = {x[31], 15'd0};
        ex = x[30:23];
        if (ex == 255)
        begin
            if (x[22:0] == 0)
            begin
                return {16'd0, sgn | 16'h7C00};
            end
            return {16'd0, sgn | 16'h7E00 | {6'd0, x[22:13]}};
        end
        if (ex == 0)
        begin
            return {16'd0, sgn};
        end
        ex = ex - 112;
        if (ex >= 31)
        begin
            return {16'd0, sgn | 16'h7C00};
        end
        if (ex <= 0)
        begin
            if (ex < -10)
            begin
                return {16'd0, sgn};
            end
            r = rne_shift({8'd0, 1'b1, x[22:0]}, 14 - ex);
            return {16'd0, sgn | r[15:0]};
        end
        r = rne_shift({9'd0, x[22:0]}, 13);
        if (r > 32'h3FF)
        begin
            ex = ex + 1;
            if (ex >= 31)
            begin
                return {16'd0, sgn | 16'h7C00};
            end
            r = 0;
        end
        return {16'd0, sgn | 16'(ex << 10) | r[15:0]};
    endfunction

    function automatic logic [31:0] to_single(input logic [15:0] h);
        int         ex;
        logic [10:0] fr;
        ex = h[14:10];
        fr = {1'b0, h[9:0]};
        if (ex == 31)
        begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        if (ex == 0)
        begin
            if (fr == 0)
            begin
                return {h[15], 31'd0};
            end
            ex = -14;
            while (!fr[10])
            begin
                fr = fr << 1;
                ex = ex - 1;
            end
            return {h[15], 8'(ex + 127), fr[9:0], 13'd0};
        end
        return {h[15], 8'(ex + 112), h[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] rand_single();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 5))
            0: x[30:23] = 8'($urandom_range(100, 114));  // subnormal band edges
            1: x[30:23] = 8'($urandom_range(140, 144));  // overflow band
            2: x[30:23] = 8'($urandom_range(0, 1) ? 255 : 0);
            3: x[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h1FFF;  // ties and carries
            default: x[30:23] = 8'($urandom_range(102, 143));
        endcase
        return x;
    endfunction

    task automatic queue_op(input hsfc_pkg::func_t fn, input logic [31:0] bits);
        pending_ops.push_back('{fn, bits});
    endtask

    initial
    begin
        logic [31:0] x;
        rst_n = 1'b0;
        stim_done = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // directed corners
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h0000_0000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h8000_0000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h7F80_0000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'hFF80_0000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h7F80_0001);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'hFFFF_FFFF);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h0000_0001);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h477F_F000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h477F_EFFF);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h3880_0000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h387F_F000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h3380_0000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h3300_0001);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h3300_0000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h3F80_1000);
        queue_op(hsfc_pkg::FUNC_NARROW, 32'h3F80_3000);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'hFFFF_0000);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'h0000_8000);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'h0000_7C00);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'h0000_7C01);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'h0000_FE00);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'h0000_0001);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'hA5A5_83FF);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'h0000_7BFF);
        queue_op(hsfc_pkg::FUNC_WIDEN,  32'h0000_0400);
        for (int i = 0; i < 750; i++)
        begin
            if ($urandom_range(0, 1))
            begin
                queue_op(hsfc_pkg::FUNC_NARROW, rand_single());
            end
            else
            begin
                x = $urandom;
                if ($urandom_range(0, 3) == 0)
                begin
                    x[14:10] = $urandom_range(0, 1) ? 5'h1F : 5'h00;
                end
                queue_op(hsfc_pkg::FUNC_WIDEN, x);
            end
        end
        stim_done = 1'b1;
    end

    // Driver: one beat per accepted start, with random idle gaps between beats.
    always @(posedge clk or negedge rst_n)
    begin
        conv_req_t op;
        if (!rst_n)
        begin
            start <= 1'b0;
            func <= 1'b0;
            operand <= '0;
            gap <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(func ? to_single(operand[15:0])
                                                : to_half(operand));
            end
            if (start && busy)
            begin
                // hold the beat until accepted
            end
            else if (gap > 0)
            begin
                start <= 1'b0;
                gap <= gap - 1;
            end
            else if (pending_ops.size() > 0)
            begin
                op = pending_ops.pop_front();
                start <= 1'b1;
                func <= op.fn;
                operand <= op.bits;
                gap <= $urandom_range(0, 7) < 2 ? 0 : $urandom_range(0, 3);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %h", result);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (result !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch: expected %h actual %h", want, result);
                    end
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > 20000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_ops.size() > 0 || start || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/hsfc_pkg.sv
rtl/core/half_single_float_convert.sv
rtl/core/hsfc_checker.sv
tb/sv/tb.sv
